@@ sv/buzzer_pattern_sequencer_defines.svh @@
// Assertion helpers for the buzzer pattern sequencer checker.
`ifndef BUZZER_PATTERN_SEQUENCER_DEFINES_SVH
`define BUZZER_PATTERN_SEQUENCER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define BPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/bps_pkg.sv @@
package bps_pkg;

  // counter width, 8..32
  localparam int unsigned TIME_BITS = 16;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CMP_W     = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
  localparam int unsigned FREQ_W    = 12;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned MODE_W    = 3;

  localparam int unsigned CFG_COUNT = 8;
  localparam int unsigned CFG_IDX_W = $clog2(CFG_COUNT);
  localparam int unsigned APB_AW    = CFG_IDX_W + 2;
  localparam int unsigned APB_DW    = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_ON    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_OFF   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_TOTAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DONE_TOTAL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WARN_ON    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WARN_OFF   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_ON   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_OFF  = 3'd7;

  localparam logic [CFG_W-1:0] CFG_RESET [CFG_COUNT] = '{
    16'd200, 16'd100, 16'd5000, 16'd3000, 16'd500, 16'd500, 16'd300, 16'd300
  };

  // commands
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

  // modes
  localparam logic [MODE_W-1:0] MODE_OFF   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_OPEN  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DONE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_WARN  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ALARM = 3'd4;

  // tones in Hz
  localparam logic [FREQ_W-1:0] FREQ_SILENT = 12'd0;
  localparam logic [FREQ_W-1:0] FREQ_2000   = 12'd2000;
  localparam logic [FREQ_W-1:0] FREQ_2500   = 12'd2500;
  localparam logic [FREQ_W-1:0] FREQ_3000   = 12'd3000;
  localparam logic [FREQ_W-1:0] FREQ_4000   = 12'd4000;

  typedef struct packed {
    logic              tone_write;
    logic [FREQ_W-1:0] tone_freq;
    logic              running;
  } res_t;

endpackage

@@ sv/buzzer_pattern_sequencer.sv @@
// Channel     Dir  Beat content
// s_axis      in   tuser[1:0] cmd, tdata[2:0] mode
// m_axis      out  tuser[0] tone_write, tdata[11:0] tone_freq, tdata[12] running
// apb         in   8 x 16-bit timing registers at 4*i
//
// One beat per cycle in while s_axis_tready is high, one registered result per beat out.
// Each beat is evaluated against the state registers in the cycle it is taken.
// A two-entry output buffer keeps input ready while one result is stalled;
// input stalls only when both entries are full.
// Reset (rst_ni low, async) idles the pattern and loads the default timings.
module buzzer_pattern_sequencer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // [2:0] mode
  input  logic [1:0]                   s_axis_tuser,   // [1:0] cmd
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [15:0]                  m_axis_tdata,   // [11:0] tone_freq, [12] running
  output logic [0:0]                   m_axis_tuser,   // [0] tone_write
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bps_pkg::APB_AW-1:0]   paddr,
  input  logic [bps_pkg::APB_DW-1:0]   pwdata,
  output logic [bps_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);

  localparam int unsigned TB = bps_pkg::TIME_BITS;
  localparam int unsigned CW = bps_pkg::CMP_W;

  logic [bps_pkg::CFG_W-1:0]  cfg_q [bps_pkg::CFG_COUNT];
  logic [bps_pkg::MODE_W-1:0] mode_q, mode_d;
  logic                       active_q, active_d;
  logic                       phase_q, phase_d;
  logic [TB-1:0]              ss_q, ss_d, ss_inc;
  logic [TB-1:0]              sc_q, sc_d, sc_inc;

  logic [bps_pkg::CMD_W-1:0]  in_cmd;
  logic [bps_pkg::MODE_W-1:0] in_mode;
  logic [bps_pkg::CFG_W-1:0]  total, on_len, off_len, lim;
  logic                       periodic;
  bps_pkg::res_t              res;

  bps_pkg::res_t              out_q, skid_q;
  logic                       out_valid_q, skid_valid_q;
  logic                       push, pop, cfg_wr;
  logic [bps_pkg::CFG_IDX_W-1:0] cfg_idx;

  assign in_cmd  = s_axis_tuser;
  assign in_mode = s_axis_tdata[bps_pkg::MODE_W-1:0];

  assign s_axis_tready = !skid_valid_q;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = out_valid_q && m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.tone_write;
  assign m_axis_tdata  = {{(16 - bps_pkg::FREQ_W - 1){1'b0}}, out_q.running, out_q.tone_freq};

  assign pready  = 1'b1;
  assign cfg_idx = paddr[bps_pkg::APB_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = {{(bps_pkg::APB_DW - bps_pkg::CFG_W){1'b0}}, cfg_q[cfg_idx]};

  assign ss_inc = (ss_q == {TB{1'b1}}) ? ss_q : ss_q + 1'b1;
  assign sc_inc = (sc_q == {TB{1'b1}}) ? sc_q : sc_q + 1'b1;

  always_comb begin
    total    = '0;
    on_len   = '0;
    off_len  = '0;
    periodic = 1'b0;
    case (mode_q)
      bps_pkg::MODE_OPEN: begin
        total    = cfg_q[bps_pkg::REG_OPEN_TOTAL];
        on_len   = cfg_q[bps_pkg::REG_OPEN_ON];
        off_len  = cfg_q[bps_pkg::REG_OPEN_OFF];
        periodic = 1'b1;
      end
      bps_pkg::MODE_DONE: begin
        total = cfg_q[bps_pkg::REG_DONE_TOTAL];
      end
      bps_pkg::MODE_WARN: begin
        on_len   = cfg_q[bps_pkg::REG_WARN_ON];
        off_len  = cfg_q[bps_pkg::REG_WARN_OFF];
        periodic = 1'b1;
      end
      bps_pkg::MODE_ALARM: begin
        on_len   = cfg_q[bps_pkg::REG_ALARM_ON];
        off_len  = cfg_q[bps_pkg::REG_ALARM_OFF];
        periodic = 1'b1;
      end
      default: ;
    endcase
    lim = phase_q ? off_len : on_len;
  end

  always_comb begin
    mode_d   = mode_q;
    active_d = active_q;
    phase_d  = phase_q;
    ss_d     = ss_q;
    sc_d     = sc_q;
    res      = '0;
    case (in_cmd)
      bps_pkg::CMD_START: begin
        mode_d   = in_mode;
        ss_d     = '0;
        sc_d     = '0;
        phase_d  = 1'b0;
        active_d = 1'b1;
      end
      bps_pkg::CMD_STOP: begin
        mode_d         = bps_pkg::MODE_OFF;
        active_d       = 1'b0;
        res.tone_write = 1'b1;
      end
      bps_pkg::CMD_TICK: begin
        if (active_q) begin
          ss_d = ss_inc;
          sc_d = sc_inc;
          if ((total != '0) && (CW'(ss_inc) >= CW'(total))) begin
            mode_d         = bps_pkg::MODE_OFF;
            active_d       = 1'b0;
            res.tone_write = 1'b1;
          end else if (periodic) begin
            if (CW'(sc_inc) >= CW'(lim)) begin
              phase_d        = !phase_q;
              sc_d           = '0;
              res.tone_write = 1'b1;
              case (mode_q)
                bps_pkg::MODE_OPEN:
                  res.tone_freq = phase_q ? bps_pkg::FREQ_2000 : bps_pkg::FREQ_2500;
                bps_pkg::MODE_WARN:
                  res.tone_freq = phase_q ? bps_pkg::FREQ_3000 : bps_pkg::FREQ_SILENT;
                default:
                  res.tone_freq = phase_q ? bps_pkg::FREQ_2000 : bps_pkg::FREQ_3000;
              endcase
            end
          end else if (mode_q == bps_pkg::MODE_DONE) begin
            // tone goes on with the first tick and then holds
            if (!phase_q) begin
              phase_d        = 1'b1;
              res.tone_write = 1'b1;
              res.tone_freq  = bps_pkg::FREQ_4000;
            end
          end else begin
            // off or unknown mode: stop on the first tick
            mode_d         = bps_pkg::MODE_OFF;
            active_d       = 1'b0;
            res.tone_write = 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.running = active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bps_pkg::CFG_COUNT; i++) begin
        cfg_q[i] <= bps_pkg::CFG_RESET[i];
      end
      mode_q       <= bps_pkg::MODE_OFF;
      active_q     <= 1'b0;
      phase_q      <= 1'b0;
      ss_q         <= '0;
      sc_q         <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        cfg_q[cfg_idx] <= pwdata[bps_pkg::CFG_W-1:0];
      end
      if (push) begin
        mode_q   <= mode_d;
        active_q <= active_d;
        phase_q  <= phase_d;
        ss_q     <= ss_d;
        sc_q     <= sc_d;
      end
      if (skid_valid_q) begin
        if (pop) begin
          skid_valid_q <= 1'b0;
        end
      end else if (push) begin
        if (out_valid_q && !pop) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, no reset
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

endmodule

@@ sv/bps_checker.sv @@
`include "buzzer_pattern_sequencer_defines.svh"

module bps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  `BPS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result beat changed while stalled")

  `BPS_ASSERT_NOW(a_quiet_freq, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[11:0] == 12'd0, "tone_freq nonzero without tone_write")

  `BPS_ASSERT_NEXT(a_stop_result, s_axis_tvalid && s_axis_tready && !m_axis_tvalid && s_axis_tuser == bps_pkg::CMD_STOP, m_axis_tvalid && m_axis_tuser[0] && m_axis_tdata == 16'd0, "stop did not give a silent idle beat")

  `BPS_ASSERT_NOW(a_stall_full, !s_axis_tready, m_axis_tvalid, "input stalled with empty output")

endmodule

bind buzzer_pattern_sequencer bps_checker u_bps_checker (.*);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam logic [bps_pkg::CMD_W-1:0]  CMD_SPARE  = 2'd3;
  localparam logic [bps_pkg::MODE_W-1:0] MODE_ABOVE = 3'd5;
  localparam logic [bps_pkg::MODE_W-1:0] MODE_BAD   = 3'd7;

  // expected beats that can be read straight off the spec
  localparam bps_pkg::res_t IDLE_NONE = '{1'b0, bps_pkg::FREQ_SILENT, 1'b0};
  localparam bps_pkg::res_t SILENCED  = '{1'b1, bps_pkg::FREQ_SILENT, 1'b0};
  localparam bps_pkg::res_t RUN_NONE  = '{1'b0, bps_pkg::FREQ_SILENT, 1'b1};
  localparam bps_pkg::res_t DONE_TONE = '{1'b1, bps_pkg::FREQ_4000, 1'b1};
  localparam bps_pkg::res_t PREDICTED = '0;

  typedef struct packed {
    logic [bps_pkg::CMD_W-1:0]  cmd;
    logic [bps_pkg::MODE_W-1:0] mode;
    logic                       typed;
    bps_pkg::res_t              want;
  } script_row_t;

  localparam int SCRIPT_LEN = 24;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{bps_pkg::CMD_TICK,  bps_pkg::MODE_OFF,   1'b1, IDLE_NONE},   // tick with nothing running
    '{bps_pkg::CMD_STOP,  bps_pkg::MODE_OFF,   1'b1, SILENCED},    // stop while idle still writes silence
    '{CMD_SPARE,          MODE_BAD,            1'b1, IDLE_NONE},
    '{bps_pkg::CMD_START, bps_pkg::MODE_OFF,   1'b1, RUN_NONE},
    '{bps_pkg::CMD_TICK,  bps_pkg::MODE_OFF,   1'b1, SILENCED},
    '{bps_pkg::CMD_START, MODE_BAD,            1'b1, RUN_NONE},
    '{bps_pkg::CMD_TICK,  MODE_BAD,            1'b1, SILENCED},
    '{bps_pkg::CMD_START, MODE_ABOVE,          1'b1, RUN_NONE},
    '{bps_pkg::CMD_TICK,  bps_pkg::MODE_OFF,   1'b1, SILENCED},
    '{bps_pkg::CMD_START, bps_pkg::MODE_DONE,  1'b1, RUN_NONE},
    '{bps_pkg::CMD_TICK,  bps_pkg::MODE_OFF,   1'b1, DONE_TONE},
    '{bps_pkg::CMD_TICK,  MODE_BAD,            1'b1, RUN_NONE},
    '{CMD_SPARE,          bps_pkg::MODE_OFF,   1'b1, RUN_NONE},
    '{bps_pkg::CMD_STOP,  bps_pkg::MODE_OFF,   1'b1, SILENCED},
    '{bps_pkg::CMD_START, bps_pkg::MODE_OPEN,  1'b0, PREDICTED},
    '{bps_pkg::CMD_TICK,  bps_pkg::MODE_OFF,   1'b0, PREDICTED},
    '{bps_pkg::CMD_START, bps_pkg::MODE_WARN,  1'b0, PREDICTED},
    '{bps_pkg::CMD_TICK,  bps_pkg::MODE_OFF,   1'b0, PREDICTED},
    '{bps_pkg::CMD_START, bps_pkg::MODE_ALARM, 1'b0, PREDICTED},
    '{bps_pkg::CMD_TICK,  bps_pkg::MODE_OFF,   1'b0, PREDICTED},
    '{CMD_SPARE,          MODE_BAD,            1'b0, PREDICTED},
    '{bps_pkg::CMD_STOP,  MODE_BAD,            1'b1, SILENCED},
    '{bps_pkg::CMD_START, bps_pkg::MODE_WARN,  1'b0, PREDICTED},
    '{bps_pkg::CMD_STOP,  bps_pkg::MODE_OFF,   1'b1, SILENCED}
  };

  logic                          clk_i;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata  = '0;   // [2:0] mode
  logic [1:0]                    s_axis_tuser  = '0;   // [1:0] cmd
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [15:0]                   m_axis_tdata;         // [11:0] tone_freq, [12] running
  logic [0:0]                    m_axis_tuser;         // [0] tone_write
  logic                          psel          = 1'b0;
  logic                          penable       = 1'b0;
  logic                          pwrite        = 1'b0;
  logic [bps_pkg::APB_AW-1:0]    paddr         = '0;
  logic [bps_pkg::APB_DW-1:0]    pwdata        = '0;
  logic [bps_pkg::APB_DW-1:0]    prdata;
  logic                          pready;

  buzzer_pattern_sequencer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // shadow of the sequencer state
  logic [bps_pkg::MODE_W-1:0]    pat_mode;
  logic                          pat_on;
  logic                          pat_phase;
  logic [bps_pkg::TIME_BITS-1:0] ticks_total;
  logic [bps_pkg::TIME_BITS-1:0] ticks_phase;
  logic [bps_pkg::CFG_W-1:0]     timing [bps_pkg::CFG_COUNT];
  logic [bps_pkg::CFG_W-1:0]     plan [bps_pkg::CFG_COUNT];

  bps_pkg::res_t pending_tones [$];
  bps_pkg::res_t got_beat;
  bps_pkg::res_t want_beat;

  int fail_count      = 0;
  int beats_sent      = 0;
  int results_checked = 0;
  int tone_writes     = 0;
  int settings_used   = 1;
  int burst_left      = 0;
  int stall_left      = 0;
  int stall_pct       = 0;
  int rx_cycles       = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(40_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic bps_pkg::res_t buzzer_next(input logic [bps_pkg::CMD_W-1:0] c,
                                                input logic [bps_pkg::MODE_W-1:0] m);
    bps_pkg::res_t              r;
    logic [bps_pkg::CFG_W-1:0]  total;
    logic [bps_pkg::CFG_W-1:0]  len_on;
    logic [bps_pkg::CFG_W-1:0]  len_off;
    logic [bps_pkg::FREQ_W-1:0] tone_a;
    logic [bps_pkg::FREQ_W-1:0] tone_b;
    r       = '0;
    total   = '0;
    len_on  = '0;
    len_off = '0;
    tone_a  = bps_pkg::FREQ_SILENT;
    tone_b  = bps_pkg::FREQ_SILENT;
    if (c == bps_pkg::CMD_START) begin
      pat_mode    = m;
      pat_on      = 1'b1;
      pat_phase   = 1'b0;
      ticks_total = '0;
      ticks_phase = '0;
    end else if (c == bps_pkg::CMD_STOP) begin
      pat_mode     = bps_pkg::MODE_OFF;
      pat_on       = 1'b0;
      r.tone_write = 1'b1;
    end else if (c == bps_pkg::CMD_TICK && pat_on) begin
      if (~&ticks_total) ticks_total = ticks_total + 1'b1;
      if (~&ticks_phase) ticks_phase = ticks_phase + 1'b1;
      case (pat_mode)
        bps_pkg::MODE_OPEN: begin
          total   = timing[bps_pkg::REG_OPEN_TOTAL];
          len_on  = timing[bps_pkg::REG_OPEN_ON];
          len_off = timing[bps_pkg::REG_OPEN_OFF];
          tone_a  = bps_pkg::FREQ_2000;
          tone_b  = bps_pkg::FREQ_2500;
        end
        bps_pkg::MODE_DONE: begin
          total = timing[bps_pkg::REG_DONE_TOTAL];
        end
        bps_pkg::MODE_WARN: begin
          len_on  = timing[bps_pkg::REG_WARN_ON];
          len_off = timing[bps_pkg::REG_WARN_OFF];
          tone_a  = bps_pkg::FREQ_3000;
        end
        bps_pkg::MODE_ALARM: begin
          len_on  = timing[bps_pkg::REG_ALARM_ON];
          len_off = timing[bps_pkg::REG_ALARM_OFF];
          tone_a  = bps_pkg::FREQ_2000;
          tone_b  = bps_pkg::FREQ_3000;
        end
        default: ;
      endcase
      // a zero total means the pattern never ends by itself
      if (total != '0 && bps_pkg::CMP_W'(ticks_total) >= bps_pkg::CMP_W'(total)) begin
        pat_mode     = bps_pkg::MODE_OFF;
        pat_on       = 1'b0;
        r.tone_write = 1'b1;
      end else if (pat_mode == bps_pkg::MODE_OPEN || pat_mode == bps_pkg::MODE_WARN ||
                   pat_mode == bps_pkg::MODE_ALARM) begin
        if (bps_pkg::CMP_W'(ticks_phase) >=
            bps_pkg::CMP_W'(pat_phase ? len_off : len_on)) begin
          pat_phase    = ~pat_phase;
          ticks_phase  = '0;
          r.tone_write = 1'b1;
          r.tone_freq  = pat_phase ? tone_b : tone_a;
        end
      end else if (pat_mode == bps_pkg::MODE_DONE) begin
        if (!pat_phase) begin
          pat_phase    = 1'b1;
          r.tone_write = 1'b1;
          r.tone_freq  = bps_pkg::FREQ_4000;
        end
      end else begin
        // off or unknown mode: first tick shuts it down
        pat_mode     = bps_pkg::MODE_OFF;
        pat_on       = 1'b0;
        r.tone_write = 1'b1;
      end
    end
    r.running = pat_on;
    return r;
  endfunction

  task automatic send_beat(input logic [bps_pkg::CMD_W-1:0] c,
                           input logic [bps_pkg::MODE_W-1:0] m,
                           input logic typed = 1'b0, input bps_pkg::res_t want = '0);
    bps_pkg::res_t r;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c;
    s_axis_tdata  <= {{(8 - bps_pkg::MODE_W){1'b0}}, m};
    do @(posedge clk_i); while (!s_axis_tready);
    r = buzzer_next(c, m);
    pending_tones.push_back(typed ? want : r);
    burst_left--;
    beats_sent++;
  endtask

  // hold off the sender until every result beat is back
  task automatic settle;
    s_axis_tvalid <= 1'b0;
    while (pending_tones.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [bps_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bps_pkg::CFG_W-1:0] val);
    logic [bps_pkg::APB_DW-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= bps_pkg::APB_DW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    timing[idx] = val;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (rd !== bps_pkg::APB_DW'(val)) begin
      $error("prdata reg %0d: expected %0d, got %0d", idx, val, rd);
      fail_count++;
    end
  endtask

  task automatic program_timing;
    for (int i = 0; i < bps_pkg::CFG_COUNT; i++) reg_write(bps_pkg::CFG_IDX_W'(i), plan[i]);
    settings_used++;
  endtask

  // mostly start-then-ticks sessions, with stray commands mixed in
  task automatic random_traffic(input int n);
    int goal;
    int len;
    goal = beats_sent + n;
    while (beats_sent < goal) begin
      if ($urandom_range(0, 9) < 7) begin
        send_beat(bps_pkg::CMD_START, bps_pkg::MODE_W'($urandom_range(1, 4)));
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 40);
        repeat (len) send_beat(bps_pkg::CMD_TICK, bps_pkg::MODE_W'($urandom_range(0, 7)));
        if ($urandom_range(0, 2) == 0)
          send_beat(bps_pkg::CMD_STOP, bps_pkg::MODE_W'($urandom_range(0, 7)));
      end else begin
        send_beat(bps_pkg::CMD_W'($urandom_range(0, 3)), bps_pkg::MODE_W'($urandom_range(0, 7)));
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_beat.tone_write = m_axis_tuser[0];
      got_beat.tone_freq  = m_axis_tdata[bps_pkg::FREQ_W-1:0];
      got_beat.running    = m_axis_tdata[bps_pkg::FREQ_W];
      if (pending_tones.size() == 0) begin
        $error("result beat with nothing pending");
        fail_count++;
      end else begin
        want_beat = pending_tones.pop_front();
        if (got_beat.tone_write !== want_beat.tone_write) begin
          $error("tone_write: expected %0d, got %0d", want_beat.tone_write, got_beat.tone_write);
          fail_count++;
        end
        if (got_beat.tone_freq !== want_beat.tone_freq) begin
          $error("tone_freq: expected %0d, got %0d", want_beat.tone_freq, got_beat.tone_freq);
          fail_count++;
        end
        if (got_beat.running !== want_beat.running) begin
          $error("running: expected %0d, got %0d", want_beat.running, got_beat.running);
          fail_count++;
        end
        results_checked++;
        if (got_beat.tone_write) tone_writes++;
      end
    end
    // receiver backpressure: random stalls whose density is redrawn among 0, 25 and 60 percent
    rx_cycles++;
    if (rx_cycles % 300 == 0) begin
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 25;
        default: stall_pct = 60;
      endcase
    end
    if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin : stimulus
    pat_mode    = bps_pkg::MODE_OFF;
    pat_on      = 1'b0;
    pat_phase   = 1'b0;
    ticks_total = '0;
    ticks_phase = '0;
    for (int i = 0; i < bps_pkg::CFG_COUNT; i++) timing[i] = bps_pkg::CFG_RESET[i];

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < SCRIPT_LEN; i++)
      send_beat(SCRIPT[i].cmd, SCRIPT[i].mode, SCRIPT[i].typed, SCRIPT[i].want);
    random_traffic(190);
    settle;

    // short timings so phases flip and patterns end often
    for (int i = 0; i < bps_pkg::CFG_COUNT; i++) plan[i] = bps_pkg::CFG_W'($urandom_range(0, 8));
    program_timing;
    random_traffic(190);
    settle;

    // all zero: flip on every tick, totals never expire
    for (int i = 0; i < bps_pkg::CFG_COUNT; i++) plan[i] = '0;
    program_timing;
    random_traffic(90);
    settle;

    // all at max: phases never flip within the run, done tone holds
    for (int i = 0; i < bps_pkg::CFG_COUNT; i++) plan[i] = '1;
    plan[bps_pkg::REG_DONE_TOTAL] = '0;
    program_timing;
    send_beat(bps_pkg::CMD_START, bps_pkg::MODE_WARN);
    repeat (60) send_beat(bps_pkg::CMD_TICK, bps_pkg::MODE_W'($urandom_range(0, 7)));
    send_beat(bps_pkg::CMD_STOP, bps_pkg::MODE_OFF);
    send_beat(bps_pkg::CMD_START, bps_pkg::MODE_DONE);
    repeat (30) send_beat(bps_pkg::CMD_TICK, bps_pkg::MODE_OFF);
    send_beat(bps_pkg::CMD_STOP, bps_pkg::MODE_OFF);
    settle;

    for (int i = 0; i < bps_pkg::CFG_COUNT; i++) plan[i] = bps_pkg::CFG_W'($urandom_range(0, 12));
    program_timing;
    random_traffic(190);
    settle;

    $display("Sent %0d command beats across %0d timing settings; %0d results checked, %0d tone writes.",
             beats_sent, settings_used, results_checked, tone_writes);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ buzzer_pattern_sequencer.f @@
+incdir+sv
sv/bps_pkg.sv
sv/buzzer_pattern_sequencer.sv
sv/bps_checker.sv
tb/sv/testbench.sv
